### hdl/i2cm_pkg.sv
// Shared types, codes and constants of the I2C master byte engine.
package i2cm_pkg;

  // Register map and reset values
  localparam int unsigned CFG_ADDR_W       = 3;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam int unsigned TICK_W           = 16;
  localparam logic [TICK_W-1:0] HALF_RESET = 16'd1200;
  localparam logic [TICK_W-1:0] ACK_RESET  = 16'd1800;

  // Register indexes
  typedef enum logic {
    REG_HALF_PERIOD = 1'b0,
    REG_ACK_PERIOD  = 1'b1
  } reg_idx_t;

  // Opcodes on the input channel
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  // Classified command carried through the queue
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_item_t;

  // Queue status toward the front and back
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

  // Bus sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_START1  = 5'd1,
    PH_START2  = 5'd2,
    PH_START3  = 5'd3,
    PH_STOP1   = 5'd4,
    PH_STOP2   = 5'd5,
    PH_STOP3   = 5'd6,
    PH_WBIT_LO = 5'd7,
    PH_WBIT_HI = 5'd8,
    PH_WACK_LO = 5'd9,
    PH_WACK_HI = 5'd10,
    PH_RBIT_LO = 5'd11,
    PH_RBIT_HI = 5'd12,
    PH_RBIT_TL = 5'd13,
    PH_RACK_LO = 5'd14,
    PH_RACK_HI = 5'd15
  } phase_t;

  // Result of one step
  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic [7:0] rx_byte;
    logic       byte_done;
    logic       ack_seen;
    logic       cmd_rejected;
  } result_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

### hdl/i2cm_front.sv
// Front end: decodes the raw opcode into a command for the queue.
module i2cm_front (
  input  logic [2:0]          in_op,
  input  logic [7:0]          in_tx_byte,
  input  logic                in_send_ack,
  input  logic                in_sda_in,
  output i2cm_pkg::cmd_item_t item
);
  import i2cm_pkg::*;

  // Map opcodes; unused codes act as a plain tick
  always_comb begin
    item.tx_byte  = in_tx_byte;
    item.send_ack = in_send_ack;
    item.sda_in   = in_sda_in;
    case (in_op)
      OP_START: item.cmd = CMD_START;
      OP_STOP:  item.cmd = CMD_STOP;
      OP_WRITE: item.cmd = CMD_WRITE;
      OP_READ:  item.cmd = CMD_READ;
      default:  item.cmd = CMD_TICK;
    endcase
  end

endmodule

### hdl/i2cm_queue.sv
// Short command queue between the front end and the bus sequencer.
module i2cm_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  i2cm_pkg::cmd_item_t     push_item,
  input  logic                    pop,
  output i2cm_pkg::cmd_item_t     pop_item,
  output i2cm_pkg::queue_status_t status
);
  import i2cm_pkg::*;

  cmd_item_t           mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign status.full  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign status.valid = (count_r != '0);
  assign pop_item     = mem[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QUEUE_AW'(push);
    rd_ptr_nxt = rd_ptr_r + QUEUE_AW'(pop);
    count_nxt  = count_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hdl/i2cm_engine.sv
// Back end: bus sequencer with half-period timer and result register.
module i2cm_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [i2cm_pkg::TICK_W-1:0] half_period,
  input  logic [i2cm_pkg::TICK_W-1:0] ack_half_period,
  input  logic                        item_valid,
  input  i2cm_pkg::cmd_item_t         item,
  output logic                        item_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output i2cm_pkg::result_t           result
);
  import i2cm_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              ack_choice_r, ack_choice_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic [7:0]        last_rx_r, last_rx_nxt;
  logic              ack_r, ack_nxt;
  logic              done, rejected;
  logic              out_valid_r;
  result_t           result_r;
  logic [TICK_W-1:0] limit;
  logic [TICK_W:0]   tick_inc;
  logic              fire;

  // Take an item when the result register is free or being emptied
  assign fire      = item_valid && (!out_valid_r || !out_stall);
  assign item_pop  = fire;
  assign out_valid = out_valid_r;
  assign result    = result_r;

  assign limit    = (phase_r == PH_WACK_LO || phase_r == PH_WACK_HI) ?
                    ack_half_period : half_period;
  assign tick_inc = {1'b0, tick_r} + {{TICK_W{1'b0}}, 1'b1};

  // Next state for one step
  always_comb begin
    phase_nxt      = phase_r;
    tick_nxt       = tick_r;
    bit_nxt        = bit_r;
    shift_nxt      = shift_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    last_rx_nxt    = last_rx_r;
    ack_nxt        = ack_r;
    done           = 1'b0;
    rejected       = (item.cmd != CMD_TICK) && (phase_r != PH_IDLE);

    if (item.cmd != CMD_TICK && phase_r == PH_IDLE) begin
      // Launch a new sequence
      tick_nxt = '0;
      case (item.cmd)
        CMD_START: begin
          sda_nxt   = 1'b0;
          scl_nxt   = 1'b0;
          phase_nxt = PH_START1;
        end
        CMD_STOP: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_STOP1;
        end
        CMD_WRITE: begin
          shift_nxt = item.tx_byte;
          bit_nxt   = 3'd7;
          sda_nxt   = ~item.tx_byte[7];
          phase_nxt = PH_WBIT_LO;
        end
        default: begin
          ack_choice_nxt = item.send_ack;
          shift_nxt      = '0;
          bit_nxt        = 3'd7;
          sda_nxt        = 1'b0;
          phase_nxt      = PH_RBIT_LO;
        end
      endcase
    end else if (phase_r != PH_IDLE) begin
      // Count one tick; act at the end of the half period
      tick_nxt = tick_inc[TICK_W-1:0];
      if (tick_inc >= {1'b0, limit}) begin
        tick_nxt = '0;
        case (phase_r)
          PH_START1: begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_START2;
          end
          PH_START2: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_START3;
          end
          PH_STOP1: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_STOP2;
          end
          PH_STOP2: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_STOP3;
          end
          PH_WBIT_LO: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_WBIT_HI;
          end
          PH_WBIT_HI: begin
            scl_nxt = 1'b1;
            if (bit_r != 3'd0) begin
              bit_nxt   = bit_r - 3'd1;
              sda_nxt   = ~shift_r[bit_r - 3'd1];
              phase_nxt = PH_WBIT_LO;
            end else begin
              sda_nxt   = 1'b0;
              phase_nxt = PH_WACK_LO;
            end
          end
          PH_WACK_LO: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_WACK_HI;
          end
          PH_WACK_HI: begin
            ack_nxt   = item.sda_in;
            scl_nxt   = 1'b1;
            done      = 1'b1;
            phase_nxt = PH_IDLE;
          end
          PH_RBIT_LO: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_RBIT_HI;
          end
          PH_RBIT_HI: begin
            shift_nxt = {shift_r[6:0], item.sda_in};
            scl_nxt   = 1'b1;
            phase_nxt = PH_RBIT_TL;
          end
          PH_RBIT_TL: begin
            if (bit_r != 3'd0) begin
              bit_nxt   = bit_r - 3'd1;
              phase_nxt = PH_RBIT_LO;
            end else begin
              sda_nxt   = ack_choice_r;
              phase_nxt = PH_RACK_LO;
            end
          end
          PH_RACK_LO: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_RACK_HI;
          end
          PH_RACK_HI: begin
            scl_nxt     = 1'b1;
            sda_nxt     = 1'b0;
            last_rx_nxt = shift_r;
            done        = 1'b1;
            phase_nxt   = PH_IDLE;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // Hold sequencer state; update on each taken item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_r       <= '0;
      bit_r        <= '0;
      shift_r      <= '0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b0;
      sda_r        <= 1'b0;
      last_rx_r    <= '0;
      ack_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        phase_r      <= phase_nxt;
        tick_r       <= tick_nxt;
        bit_r        <= bit_nxt;
        shift_r      <= shift_nxt;
        ack_choice_r <= ack_choice_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        last_rx_r    <= last_rx_nxt;
        ack_r        <= ack_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (fire) begin
      result_r.scl_low      <= scl_nxt;
      result_r.sda_low      <= sda_nxt;
      result_r.busy_res     <= (phase_nxt != PH_IDLE);
      result_r.rx_byte      <= last_rx_nxt;
      result_r.byte_done    <= done;
      result_r.ack_seen     <= ack_nxt;
      result_r.cmd_rejected <= rejected;
    end
  end

endmodule

### hdl/i2c_master_byte_engine_top.sv
// Top level of the I2C master byte engine: register port, front end, queue, sequencer.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------
//  in_      | in_valid / in_stall     | op, tx_byte, send_ack, sda_in
//  out_     | out_valid / out_stall   | scl_low, sda_low, busy_res, rx_byte,
//           |                         | byte_done, ack_seen, cmd_rejected
//  config   | psel/penable/pwrite     | paddr 0: half period, 4: ACK half period
//
// One transaction in, one result out, one per cycle sustained while out_stall is low;
// each passes the queue write, then the sequencer step into the result register.
// The rate is set by the sequencer state update.
// rst_n is synchronous: the queue empties, the sequencer goes idle and the
// half-period registers return to 1200 and 1800 ticks.
// out_stall holds the result register; the four-entry queue absorbs input until full,
// then in_stall rises.
module i2c_master_byte_engine_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_op,
  input  logic [7:0]                          in_tx_byte,
  input  logic                                in_send_ack,
  input  logic                                in_sda_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_scl_low,
  output logic                                out_sda_low,
  output logic                                out_busy_res,
  output logic [7:0]                          out_rx_byte,
  output logic                                out_byte_done,
  output logic                                out_ack_seen,
  output logic                                out_cmd_rejected,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2cm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [i2cm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import i2cm_pkg::*;

  logic [TICK_W-1:0] half_r, ack_half_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;
  cmd_item_t         front_item, queue_item;
  queue_status_t     q_status;
  logic              push, pop;
  result_t           result;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (reg_idx == REG_ACK_PERIOD) ?
                   {{(CFG_DATA_W-TICK_W){1'b0}}, ack_half_r} :
                   {{(CFG_DATA_W-TICK_W){1'b0}}, half_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r     <= HALF_RESET;
      ack_half_r <= ACK_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HALF_PERIOD: half_r     <= pwdata[TICK_W-1:0];
        REG_ACK_PERIOD:  ack_half_r <= pwdata[TICK_W-1:0];
        default:         half_r     <= half_r;
      endcase
    end
  end

  // Accept transactions while the queue has room
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  i2cm_front u_front (
    .in_op       (in_op),
    .in_tx_byte  (in_tx_byte),
    .in_send_ack (in_send_ack),
    .in_sda_in   (in_sda_in),
    .item        (front_item)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .pop_item  (queue_item),
    .status    (q_status)
  );

  i2cm_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .half_period     (half_r),
    .ack_half_period (ack_half_r),
    .item_valid      (q_status.valid),
    .item            (queue_item),
    .item_pop        (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result          (result)
  );

  assign out_scl_low      = result.scl_low;
  assign out_sda_low      = result.sda_low;
  assign out_busy_res     = result.busy_res;
  assign out_rx_byte      = result.rx_byte;
  assign out_byte_done    = result.byte_done;
  assign out_ack_seen     = result.ack_seen;
  assign out_cmd_rejected = result.cmd_rejected;

endmodule

### test/i2c_master_byte_engine_top_test.sv
// Self-checking testbench for the I2C master byte engine top level.
`timescale 1ns / 100ps

module i2c_master_byte_engine_top_test;
  import i2cm_pkg::*;

  // Opcodes outside the command set; the engine treats them as plain ticks
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic [2:0] op;
    logic [7:0] tx;
    logic       ack;
    logic       sda;
  } bus_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            in_op = OP_TICK;
  logic [7:0]            in_tx_byte = 8'h00;
  logic                  in_send_ack = 1'b0;
  logic                  in_sda_in = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_scl_low;
  logic                  out_sda_low;
  logic                  out_busy_res;
  logic [7:0]            out_rx_byte;
  logic                  out_byte_done;
  logic                  out_ack_seen;
  logic                  out_cmd_rejected;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  i2c_master_byte_engine_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_tx_byte       (in_tx_byte),
    .in_send_ack      (in_send_ack),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl_low      (out_scl_low),
    .out_sda_low      (out_sda_low),
    .out_busy_res     (out_busy_res),
    .out_rx_byte      (out_rx_byte),
    .out_byte_done    (out_byte_done),
    .out_ack_seen     (out_ack_seen),
    .out_cmd_rejected (out_cmd_rejected),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #6 clk = ~clk;

  // Stimulus waiting to be driven, bus states waiting to be seen
  bus_item_t cmd_queue[$];
  result_t   bus_expect[$];
  int unsigned item_cnt = 0;
  int unsigned fails = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  // Shadow of the sequencer and its half-period registers
  phase_t      bus_phase;
  logic [16:0] tick_cnt;
  logic [3:0]  bit_pos;
  logic [7:0]  shifter;
  logic        ack_pick;
  logic        scl_pull;
  logic        sda_pull;
  logic [7:0]  rx_last;
  logic        ack_level;
  logic [15:0] half_ticks;
  logic [15:0] ack_ticks;

  // Advance the shadow sequencer by one transaction and return the bus state after it
  function automatic result_t bus_step(logic [2:0] op_in, logic [7:0] tx, logic sack,
                                       logic sda);
    logic [2:0]  op;
    logic        done;
    logic        rej;
    logic [16:0] lim;
    result_t     r;
    op = (op_in > OP_READ) ? OP_TICK : op_in;
    done = 1'b0;
    rej = (op != OP_TICK) && (bus_phase != PH_IDLE);
    if (op != OP_TICK && bus_phase == PH_IDLE) begin
      tick_cnt = '0;
      case (op)
        OP_START: begin
          sda_pull = 1'b0;
          scl_pull = 1'b0;
          bus_phase = PH_START1;
        end
        OP_STOP: begin
          sda_pull = 1'b1;
          bus_phase = PH_STOP1;
        end
        OP_WRITE: begin
          shifter = tx;
          bit_pos = 4'd7;
          sda_pull = ~tx[7];
          bus_phase = PH_WBIT_LO;
        end
        default: begin
          ack_pick = sack;
          shifter = '0;
          bit_pos = 4'd7;
          sda_pull = 1'b0;
          bus_phase = PH_RBIT_LO;
        end
      endcase
    end else if (bus_phase != PH_IDLE) begin
      lim = (bus_phase == PH_WACK_LO || bus_phase == PH_WACK_HI) ? ack_ticks : half_ticks;
      tick_cnt = tick_cnt + 17'd1;
      if (tick_cnt >= lim) begin
        tick_cnt = '0;
        case (bus_phase)
          PH_START1: begin sda_pull = 1'b1; bus_phase = PH_START2; end
          PH_START2: begin scl_pull = 1'b1; bus_phase = PH_START3; end
          PH_START3: bus_phase = PH_IDLE;
          PH_STOP1:  begin scl_pull = 1'b0; bus_phase = PH_STOP2; end
          PH_STOP2:  begin sda_pull = 1'b0; bus_phase = PH_STOP3; end
          PH_STOP3:  bus_phase = PH_IDLE;
          PH_WBIT_LO: begin scl_pull = 1'b0; bus_phase = PH_WBIT_HI; end
          PH_WBIT_HI: begin
            scl_pull = 1'b1;
            if (bit_pos > 0) begin
              bit_pos = bit_pos - 4'd1;
              sda_pull = ~shifter[bit_pos[2:0]];
              bus_phase = PH_WBIT_LO;
            end else begin
              sda_pull = 1'b0;
              bus_phase = PH_WACK_LO;
            end
          end
          PH_WACK_LO: begin scl_pull = 1'b0; bus_phase = PH_WACK_HI; end
          PH_WACK_HI: begin
            ack_level = sda;
            scl_pull = 1'b1;
            done = 1'b1;
            bus_phase = PH_IDLE;
          end
          PH_RBIT_LO: begin scl_pull = 1'b0; bus_phase = PH_RBIT_HI; end
          PH_RBIT_HI: begin
            shifter = {shifter[6:0], sda};
            scl_pull = 1'b1;
            bus_phase = PH_RBIT_TL;
          end
          PH_RBIT_TL: begin
            if (bit_pos > 0) begin
              bit_pos = bit_pos - 4'd1;
              bus_phase = PH_RBIT_LO;
            end else begin
              sda_pull = ack_pick;
              bus_phase = PH_RACK_LO;
            end
          end
          PH_RACK_LO: begin scl_pull = 1'b0; bus_phase = PH_RACK_HI; end
          PH_RACK_HI: begin
            scl_pull = 1'b1;
            sda_pull = 1'b0;
            rx_last = shifter;
            done = 1'b1;
            bus_phase = PH_IDLE;
          end
          default: bus_phase = PH_IDLE;
        endcase
      end
    end
    r.scl_low = scl_pull;
    r.sda_low = sda_pull;
    r.busy_res = (bus_phase != PH_IDLE);
    r.rx_byte = rx_last;
    r.byte_done = done;
    r.ack_seen = ack_level;
    r.cmd_rejected = rej;
    return r;
  endfunction

  // Ticks a command keeps the engine busy under the current registers
  function automatic int unsigned busy_ticks(logic [2:0] op);
    int unsigned h;
    int unsigned a;
    h = (half_ticks == 0) ? 1 : half_ticks;
    a = (ack_ticks == 0) ? 1 : ack_ticks;
    case (op)
      OP_START, OP_STOP: return 3 * h;
      OP_WRITE:          return 16 * h + 2 * a;
      OP_READ:           return 26 * h;
      default:           return 0;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  // Drive the input channel from the pending queue; predict each accepted transaction
  always @(posedge clk) begin : drive_in
    bus_item_t nxt;
    logic      take;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      if (take) bus_expect.push_back(bus_step(in_op, in_tx_byte, in_send_ack, in_sda_in));
      if (!in_valid || take) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
          nxt = cmd_queue.pop_front();
          in_op <= nxt.op;
          in_tx_byte <= nxt.tx;
          in_send_ack <= nxt.ack;
          in_sda_in <= nxt.sda;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Compare each accepted result with the oldest prediction; stall at random
  always @(posedge clk) begin : watch_out
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (bus_expect.size() == 0) begin
          $error("result transaction with no prediction pending");
          fails++;
        end else begin
          want = bus_expect.pop_front();
          check_field("scl_low", want.scl_low, out_scl_low);
          check_field("sda_low", want.sda_low, out_sda_low);
          check_field("busy_res", want.busy_res, out_busy_res);
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("byte_done", want.byte_done, out_byte_done);
          check_field("ack_seen", want.ack_seen, out_ack_seen);
          check_field("cmd_rejected", want.cmd_rejected, out_cmd_rejected);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic push(logic [2:0] op, logic [7:0] tx, logic sack, logic sda);
    bus_item_t it;
    it.op = op;
    it.tx = tx;
    it.ack = sack;
    it.sda = sda;
    cmd_queue.push_back(it);
    item_cnt++;
  endtask

  // Queue n timing transactions; while busy, some may be stray commands
  task automatic push_wait(int unsigned n, bit noisy);
    int unsigned r;
    logic [2:0]  op;
    repeat (n) begin
      r = $urandom_range(99);
      if (noisy && r < 8) op = 3'($urandom_range(OP_START, OP_READ));
      else if (r >= 90) op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      else op = OP_TICK;
      push(op, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // Queue a command, exactly enough ticks to finish it, then a short idle gap
  task automatic run_cmd(logic [2:0] op, logic [7:0] tx, logic sack);
    push(op, tx, sack, 1'($urandom_range(1)));
    push_wait(busy_ticks(op), 1'b1);
    push_wait($urandom_range(2), 1'b0);
  endtask

  // Hold until every queued transaction is driven and every result has arrived
  task automatic drain();
    @(posedge clk);
    while (cmd_queue.size() != 0 || in_valid || bus_expect.size() != 0) @(posedge clk);
  endtask

  // Tick the engine until the shadow sequencer is back to idle
  task automatic settle();
    drain();
    while (bus_phase != PH_IDLE) begin
      push_wait(8, 1'b0);
      drain();
    end
  endtask

  // Register write over the APB port, only with the channels quiet
  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    logic [15:0] junk;
    drain();
    repeat (4) @(posedge clk);
    junk = 16'($urandom_range(16'hFFFF));
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * int'(idx));
    pwdata <= {junk, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_HALF_PERIOD) half_ticks = val;
    else ack_ticks = val;
  endtask

  initial begin
    int unsigned base;
    bus_phase = PH_IDLE;
    tick_cnt = '0;
    bit_pos = '0;
    shifter = '0;
    ack_pick = 1'b0;
    scl_pull = 1'b0;
    sda_pull = 1'b0;
    rx_last = '0;
    ack_level = 1'b0;
    half_ticks = HALF_RESET;
    ack_ticks = ACK_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero half period, stray commands while busy, spare opcodes,
    // all-ones and all-zeros writes, read with ACK and with NACK
    write_reg(REG_HALF_PERIOD, 16'd0);
    write_reg(REG_ACK_PERIOD, 16'd1);
    push(OP_TICK, 8'h00, 1'b0, 1'b0);
    push(OP_START, 8'h00, 1'b0, 1'b1);
    push(OP_WRITE, 8'hFF, 1'b1, 1'b1);
    push(OP_UNUSED_FIRST, 8'h00, 1'b0, 1'b0);
    push(OP_UNUSED_LAST, 8'hFF, 1'b1, 1'b1);
    run_cmd(OP_WRITE, 8'hFF, 1'b0);
    run_cmd(OP_WRITE, 8'h00, 1'b1);
    run_cmd(OP_READ, 8'h5A, 1'b1);
    run_cmd(OP_READ, 8'hA5, 1'b0);
    push(OP_UNUSED_FIRST + 3'd1, 8'h3C, 1'b1, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0);

    // Longest half period, then shrink it below the running count
    write_reg(REG_HALF_PERIOD, 16'hFFFF);
    push(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    push_wait(120, 1'b1);
    drain();
    write_reg(REG_HALF_PERIOD, 16'd3);
    settle();

    // Longest ACK half period in a write, then shrink it mid-slot
    write_reg(REG_HALF_PERIOD, 16'd1);
    write_reg(REG_ACK_PERIOD, 16'hFFFF);
    push(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    push_wait(16 + 40, 1'b1);
    drain();
    write_reg(REG_ACK_PERIOD, 16'd2);
    settle();

    // Random traffic: mostly framed transfers, some bare commands, per idling mode
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_HALF_PERIOD, 16'($urandom_range(1, 3)));
      write_reg(REG_ACK_PERIOD, 16'($urandom_range(1, 4)));
      case (m)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 62; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 62; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      base = item_cnt;
      while (item_cnt - base < 280) begin
        if ($urandom_range(99) < 80) begin
          run_cmd(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
          repeat ($urandom_range(1, 3)) begin
            run_cmd($urandom_range(1) ? OP_WRITE : OP_READ, 8'($urandom_range(255)),
                    1'($urandom_range(1)));
          end
          run_cmd(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
          run_cmd(3'($urandom_range(OP_START, OP_READ)), 8'($urandom_range(255)),
                  1'($urandom_range(1)));
        end
      end
      drain();
    end

    gap_pct = 0;
    stall_pct = 0;
    drain();
    repeat (10) @(posedge clk);
    if (fails == 0 && bus_expect.size() == 0) begin
      $display("i2c_master_byte_engine_top regression: pass");
    end else begin
      $display("i2c_master_byte_engine_top regression: fail");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #10_000_000;
    $display("i2c_master_byte_engine_top regression: fail");
    $finish;
  end

endmodule
